// ===== rtl/core/twh_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer wheel package
// Shared sizes, codes and structures of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package twh_pkg;

  localparam int WHEEL_COUNT  = 4;
  localparam int SLOT_BITS    = 8;
  localparam int POOL_ENTRIES = 64;
  localparam int TICK_BITS    = 32;

  localparam int SLOT_COUNT  = 1 << SLOT_BITS;
  localparam int SLOT_DEPTH  = WHEEL_COUNT * SLOT_COUNT;
  localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
  localparam int HW          = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW          = HW + 1;
  localparam int WW          = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  localparam logic [LW-1:0] NIL = {LW{1'b1}};

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] RES_GRANT   = 2'd0;
  localparam logic [1:0] RES_FULL    = 2'd1;
  localparam logic [1:0] RES_SIGNAL  = 2'd2;
  localparam logic [1:0] RES_RELEASE = 2'd3;

  typedef struct packed {
    logic [TICK_BITS-1:0] end_time;
    logic [15:0]          tag;
    logic [7:0]           ekind;
    logic [LW-1:0]        link;
  } entry_t;

  typedef struct packed {
    logic          rd_en;
    logic [HW-1:0] rd_addr;
    logic          wr_data_en;
    logic          wr_link_en;
    logic [HW-1:0] wr_addr;
    entry_t        wr_word;
  } ent_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic [LW-1:0]      wr_head;
  } slot_req_t;

  typedef struct packed {
    logic        push;
    logic        flush;
    logic [1:0]  kind;
    logic [5:0]  handle;
    logic [15:0] tag;
    logic [7:0]  ekind;
  } out_cmd_t;

  typedef struct packed {
    logic ready;
    logic hold_vld;
  } out_sts_t;

endpackage

// ===== rtl/core/twh_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Slot head memory
// One list head per slot of every wheel, with a registered read.
// ----------------------------------------------------------------------------
module twh_slot_ram (
  input  logic                     clk_i,
  input  twh_pkg::slot_req_t       req_i,
  output logic [twh_pkg::LW-1:0]   rd_head_o
);

  logic [twh_pkg::LW-1:0] mem_q [twh_pkg::SLOT_DEPTH];
  logic [twh_pkg::LW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_head;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_head_o = rd_q;

endmodule

// ===== rtl/core/twh_entry_ram.sv =====
// ----------------------------------------------------------------------------
// Entry memory
// End time, event identity and list link of every pool entry.
// ----------------------------------------------------------------------------
module twh_entry_ram (
  input  logic              clk_i,
  input  twh_pkg::ent_req_t req_i,
  output twh_pkg::entry_t   rd_word_o
);

  twh_pkg::entry_t mem_q [twh_pkg::POOL_ENTRIES];
  twh_pkg::entry_t rd_q;

  // The link field is written on its own while lists are spliced.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_data_en) begin
      mem_q[req_i.wr_addr].end_time <= req_i.wr_word.end_time;
      mem_q[req_i.wr_addr].tag      <= req_i.wr_word.tag;
      mem_q[req_i.wr_addr].ekind    <= req_i.wr_word.ekind;
    end
    if (req_i.wr_link_en) begin
      mem_q[req_i.wr_addr].link <= req_i.wr_word.link;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_word_o = rd_q;

endmodule

// ===== rtl/core/twh_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result output buffer
// Holds one result back so the final word of an item can carry last.
// ----------------------------------------------------------------------------
module twh_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  twh_pkg::out_cmd_t cmd_i,
  output twh_pkg::out_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        result_kind_o,
  output logic [5:0]        result_handle_o,
  output logic [15:0]       result_event_tag_o,
  output logic [7:0]        result_event_kind_o,
  output logic              last_o
);

  logic        hold_vld_q, hold_vld_d;
  logic        out_vld_q, out_vld_d;
  logic [1:0]  hold_kind_q;
  logic [5:0]  hold_handle_q;
  logic [15:0] hold_tag_q;
  logic [7:0]  hold_ekind_q;
  logic [1:0]  out_kind_q;
  logic [5:0]  out_handle_q;
  logic [15:0] out_tag_q;
  logic [7:0]  out_ekind_q;
  logic        out_last_q;
  logic        rdy;
  logic        load_out;
  logic        load_hold;

  assign rdy       = !hold_vld_q || !out_vld_q || !out_stall_i;
  assign load_hold = cmd_i.push && rdy;
  assign load_out  = rdy && hold_vld_q && (cmd_i.push || cmd_i.flush);

  always_comb begin
    out_vld_d  = load_out ? 1'b1 : (out_vld_q && out_stall_i);
    hold_vld_d = hold_vld_q;
    if (load_hold) begin
      hold_vld_d = 1'b1;
    end else if (cmd_i.flush && rdy) begin
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q   <= hold_kind_q;
      out_handle_q <= hold_handle_q;
      out_tag_q    <= hold_tag_q;
      out_ekind_q  <= hold_ekind_q;
      out_last_q   <= !cmd_i.push;
    end
    if (load_hold) begin
      hold_kind_q   <= cmd_i.kind;
      hold_handle_q <= cmd_i.handle;
      hold_tag_q    <= cmd_i.tag;
      hold_ekind_q  <= cmd_i.ekind;
    end
  end

  assign sts_o.ready         = rdy;
  assign sts_o.hold_vld      = hold_vld_q;
  assign out_valid_o         = out_vld_q;
  assign result_kind_o       = out_kind_q;
  assign result_handle_o     = out_handle_q;
  assign result_event_tag_o  = out_tag_q;
  assign result_event_kind_o = out_ekind_q;
  assign last_o              = out_last_q;

endmodule

// ===== rtl/core/hierarchical_timer_wheel_top.sv =====
// ----------------------------------------------------------------------------
// Hierarchical timer wheel
// Timeout engine: start, cancel and tick words driving a pool of timers.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word (opcode and operands) when
// in_valid_i is high and in_stall_o is low. A start answers with one result
// word (a granted handle or pool full), placed in the holding buffer in
// S_START and moved to the output in S_FLUSH; a granted entry joins a
// nonempty pending queue in S_PLINK between them. The next word is taken
// once the engine is back in idle. A cancel gives no result. A tick walks
// the slot memory: a setup step per wheel, a read of each slot whose digit
// advanced, a walk over each entry of a drained list, a join of the pending
// queue, then a read and handling of each entry; for an entry that goes back
// on a wheel its slot is read and, when that list is nonempty, walked to
// append it; a final flush step ends the item. Its results (signaled and
// released entries) leave in order; the last word of an item has last_o set.
// The output channel holds a word while out_stall_i is high; the engine
// then waits on its one-word holding buffer and resumes when it drains.
// After reset the slot memory is cleared, one slot per cycle, for all
// WHEEL_COUNT * 2^SLOT_BITS (1024) slots; in_stall_o stays high meanwhile.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] clock_value_i,
  input  logic [31:0] timeout_i,
  input  logic [15:0] event_tag_i,
  input  logic [7:0]  event_kind_i,
  input  logic [5:0]  handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [5:0]  result_handle_o,
  output logic [15:0] result_event_tag_o,
  output logic [7:0]  result_event_kind_o,
  output logic        last_o
);

  localparam int TB = twh_pkg::TICK_BITS;
  localparam int HW = twh_pkg::HW;
  localparam int LW = twh_pkg::LW;
  localparam int WW = twh_pkg::WW;
  localparam int SB = twh_pkg::SLOT_BITS;
  localparam int AW = twh_pkg::SLOT_AW;
  localparam int PE = twh_pkg::POOL_ENTRIES;

  typedef enum logic [16:0] {
    S_CLEAR   = 17'h00001,
    S_IDLE    = 17'h00002,
    S_START   = 17'h00004,
    S_PLINK   = 17'h00008,
    S_FLUSH   = 17'h00010,
    S_WSETUP  = 17'h00020,
    S_SRD     = 17'h00040,
    S_SHEAD   = 17'h00080,
    S_WALK_RD = 17'h00100,
    S_WALK    = 17'h00200,
    S_PEND    = 17'h00400,
    S_HRD     = 17'h00800,
    S_HDO     = 17'h01000,
    S_PRD     = 17'h02000,
    S_PHEAD   = 17'h04000,
    S_PWRD    = 17'h08000,
    S_PW      = 17'h10000
  } state_e;

  state_e            state_q, state_d;
  logic [TB-1:0]     cur_time_q, cur_time_d;
  logic [TB-1:0]     tick_q, tick_d;
  logic [TB-1:0]     end_q, end_d;
  logic [15:0]       tag_q, tag_d;
  logic [7:0]        kind_q, kind_d;
  logic [HW-1:0]     free_q, free_d;
  logic              full_q, full_d;
  logic [WW-1:0]     wheel_q, wheel_d;
  logic [SB:0]       adv_q, adv_d;
  logic [SB-1:0]     slot_q, slot_d;
  logic [LW-1:0]     chain_head_q, chain_head_d;
  logic [LW-1:0]     chain_tail_q, chain_tail_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     nx_q, nx_d;
  logic [LW-1:0]     walk_q, walk_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [LW-1:0]     pend_head_q, pend_head_d;
  logic [LW-1:0]     pend_tail_q, pend_tail_d;
  logic [PE-1:0]     inuse_q, inuse_d;
  logic [PE-1:0]     caller_q, caller_d;
  logic [PE-1:0]     whold_q, whold_d;

  twh_pkg::ent_req_t  ent_req;
  twh_pkg::entry_t    ent_rd;
  twh_pkg::slot_req_t slot_req;
  logic [LW-1:0]      slot_rd;
  twh_pkg::out_cmd_t  ob_cmd;
  twh_pkg::out_sts_t  ob_sts;

  logic              in_acc;
  logic [HW-1:0]     free_v;
  logic [HW-1:0]     hcur;
  int                shamt;
  logic [TB-1:0]     diff;
  logic [TB-1:0]     delay;
  logic              due;
  logic [WW-1:0]     pw;
  logic [SB-1:0]     pslot;
  logic              nxt_slot;
  logic              nxt_ent;
  logic [LW-1:0]     nxt_val;
  logic [LW-1:0]     first_v;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign hcur       = cur_q[HW-1:0];

  // Lowest free entry of the pool.
  always_comb begin
    free_v = '0;
    for (int i = PE - 1; i >= 0; i--) begin
      if (!inuse_q[i]) free_v = HW'(i);
    end
  end

  // Remaining delay of the entry just read, and the wheel it belongs on.
  always_comb begin
    delay = ent_rd.end_time - cur_time_q;
    due   = (delay == '0) || delay[TB-1];
    pw    = '0;
    for (int w = 1; w < twh_pkg::WHEEL_COUNT; w++) begin
      if ((64'(delay) >> (w * SB)) != 64'd0) pw = WW'(w);
    end
    pslot = SB'(ent_rd.end_time >> (int'(pw) * SB)) - SB'(pw != '0);
  end

  always_comb begin
    shamt = int'(wheel_q) * SB;
    diff  = ((tick_q >> shamt) - (cur_time_q >> shamt)) & ({TB{1'b1}} >> shamt);
  end

  always_comb begin
    state_d      = state_q;
    cur_time_d   = cur_time_q;
    tick_d       = tick_q;
    end_d        = end_q;
    tag_d        = tag_q;
    kind_d       = kind_q;
    free_d       = free_q;
    full_d       = full_q;
    wheel_d      = wheel_q;
    adv_d        = adv_q;
    slot_d       = slot_q;
    chain_head_d = chain_head_q;
    chain_tail_d = chain_tail_q;
    cur_d        = cur_q;
    nx_d         = nx_q;
    walk_d       = walk_q;
    pidx_d       = pidx_q;
    clr_d        = clr_q;
    pend_head_d  = pend_head_q;
    pend_tail_d  = pend_tail_q;
    inuse_d      = inuse_q;
    caller_d     = caller_q;
    whold_d      = whold_q;
    nxt_slot     = 1'b0;
    nxt_ent      = 1'b0;
    nxt_val      = nx_q;
    first_v      = chain_head_q;

    ent_req         = '0;
    ent_req.wr_word = '{end_time: end_q, tag: tag_q, ekind: kind_q, link: twh_pkg::NIL};
    slot_req        = '0;
    slot_req.wr_head = twh_pkg::NIL;
    ob_cmd          = '0;
    ob_cmd.tag      = tag_q;
    ob_cmd.ekind    = kind_q;

    unique case (state_q)
      S_CLEAR: begin
        slot_req.wr_en   = 1'b1;
        slot_req.wr_addr = clr_q;
        clr_d            = clr_q + AW'(1);
        if (clr_q == AW'(twh_pkg::SLOT_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (opcode_i)
            twh_pkg::OP_START: begin
              end_d   = TB'(TB'(clock_value_i) + TB'(timeout_i));
              tag_d   = event_tag_i;
              kind_d  = event_kind_i;
              free_d  = free_v;
              full_d  = &inuse_q;
              state_d = S_START;
            end
            twh_pkg::OP_CANCEL: begin
              if (int'(handle_i) < PE && inuse_q[handle_i[HW-1:0]] &&
                  caller_q[handle_i[HW-1:0]]) begin
                caller_d[handle_i[HW-1:0]] = 1'b0;
                if (!whold_q[handle_i[HW-1:0]]) inuse_d[handle_i[HW-1:0]] = 1'b0;
              end
            end
            twh_pkg::OP_TICK: begin
              tick_d       = TB'(clock_value_i);
              wheel_d      = '0;
              chain_head_d = twh_pkg::NIL;
              chain_tail_d = twh_pkg::NIL;
              state_d      = S_WSETUP;
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        ob_cmd.push = 1'b1;
        if (full_q) begin
          ob_cmd.kind   = twh_pkg::RES_FULL;
          ob_cmd.handle = '0;
          if (ob_sts.ready) state_d = S_FLUSH;
        end else begin
          ob_cmd.kind   = twh_pkg::RES_GRANT;
          ob_cmd.handle = 6'(free_q);
          if (ob_sts.ready) begin
            ent_req.wr_data_en = 1'b1;
            ent_req.wr_link_en = 1'b1;
            ent_req.wr_addr    = free_q;
            inuse_d[free_q]    = 1'b1;
            caller_d[free_q]   = 1'b1;
            whold_d[free_q]    = 1'b1;
            if (pend_tail_q == twh_pkg::NIL) begin
              pend_head_d = LW'(free_q);
              pend_tail_d = LW'(free_q);
              state_d     = S_FLUSH;
            end else begin
              state_d = S_PLINK;
            end
          end
        end
      end
      S_PLINK: begin
        ent_req.wr_link_en   = 1'b1;
        ent_req.wr_addr      = pend_tail_q[HW-1:0];
        ent_req.wr_word.link = LW'(free_q);
        pend_tail_d          = LW'(free_q);
        state_d              = S_FLUSH;
      end
      S_FLUSH: begin
        ob_cmd.flush = 1'b1;
        if (ob_sts.ready) state_d = S_IDLE;
      end
      S_WSETUP: begin
        if (shamt >= TB) begin
          state_d = S_PEND;
        end else begin
          adv_d  = (64'(diff) > 64'(twh_pkg::SLOT_COUNT)) ?
                   (SB + 1)'(twh_pkg::SLOT_COUNT) : (SB + 1)'(diff);
          slot_d = SB'(cur_time_q >> shamt);
          if (diff == '0) begin
            if (wheel_q == WW'(twh_pkg::WHEEL_COUNT - 1)) begin
              state_d = S_PEND;
            end else begin
              wheel_d = wheel_q + WW'(1);
            end
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        slot_req.rd_en   = 1'b1;
        slot_req.rd_addr = AW'({wheel_q, slot_q});
        state_d          = S_SHEAD;
      end
      S_SHEAD: begin
        // The drained slot is emptied and its list spliced onto the batch chain.
        slot_req.wr_en   = 1'b1;
        slot_req.wr_addr = AW'({wheel_q, slot_q});
        if (slot_rd == twh_pkg::NIL) begin
          nxt_slot = 1'b1;
        end else begin
          if (chain_head_q == twh_pkg::NIL) begin
            chain_head_d = slot_rd;
          end else begin
            ent_req.wr_link_en   = 1'b1;
            ent_req.wr_addr      = chain_tail_q[HW-1:0];
            ent_req.wr_word.link = slot_rd;
          end
          cur_d   = slot_rd;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        ent_req.rd_en   = 1'b1;
        ent_req.rd_addr = hcur;
        state_d         = S_WALK;
      end
      S_WALK: begin
        if (ent_rd.link == twh_pkg::NIL) begin
          chain_tail_d = cur_q;
          nxt_slot     = 1'b1;
        end else begin
          cur_d   = ent_rd.link;
          state_d = S_WALK_RD;
        end
      end
      S_PEND: begin
        cur_time_d  = tick_q;
        pend_head_d = twh_pkg::NIL;
        pend_tail_d = twh_pkg::NIL;
        if (pend_head_q != twh_pkg::NIL) begin
          if (chain_head_q == twh_pkg::NIL) begin
            first_v = pend_head_q;
          end else begin
            ent_req.wr_link_en   = 1'b1;
            ent_req.wr_addr      = chain_tail_q[HW-1:0];
            ent_req.wr_word.link = pend_head_q;
          end
        end
        cur_d   = first_v;
        state_d = (first_v == twh_pkg::NIL) ? S_FLUSH : S_HRD;
      end
      S_HRD: begin
        ent_req.rd_en   = 1'b1;
        ent_req.rd_addr = hcur;
        state_d         = S_HDO;
      end
      S_HDO: begin
        nx_d          = ent_rd.link;
        nxt_val       = ent_rd.link;
        ob_cmd.handle = 6'(hcur);
        ob_cmd.tag    = ent_rd.tag;
        if (due) begin
          ob_cmd.push  = 1'b1;
          ob_cmd.kind  = twh_pkg::RES_SIGNAL;
          ob_cmd.ekind = ent_rd.ekind;
          if (ob_sts.ready) begin
            whold_d[hcur] = 1'b0;
            if (!caller_q[hcur]) inuse_d[hcur] = 1'b0;
            nxt_ent = 1'b1;
          end
        end else if (!caller_q[hcur]) begin
          ob_cmd.push  = 1'b1;
          ob_cmd.kind  = twh_pkg::RES_RELEASE;
          ob_cmd.ekind = '0;
          if (ob_sts.ready) begin
            whold_d[hcur] = 1'b0;
            inuse_d[hcur] = 1'b0;
            nxt_ent       = 1'b1;
          end
        end else begin
          ent_req.wr_link_en = 1'b1;
          ent_req.wr_addr    = hcur;
          pidx_d             = AW'({pw, pslot});
          state_d            = S_PRD;
        end
      end
      S_PRD: begin
        slot_req.rd_en   = 1'b1;
        slot_req.rd_addr = pidx_q;
        state_d          = S_PHEAD;
      end
      S_PHEAD: begin
        if (slot_rd == twh_pkg::NIL) begin
          slot_req.wr_en   = 1'b1;
          slot_req.wr_addr = pidx_q;
          slot_req.wr_head = cur_q;
          nxt_ent          = 1'b1;
        end else begin
          walk_d  = slot_rd;
          state_d = S_PWRD;
        end
      end
      S_PWRD: begin
        ent_req.rd_en   = 1'b1;
        ent_req.rd_addr = walk_q[HW-1:0];
        state_d         = S_PW;
      end
      S_PW: begin
        if (ent_rd.link == twh_pkg::NIL) begin
          ent_req.wr_link_en   = 1'b1;
          ent_req.wr_addr      = walk_q[HW-1:0];
          ent_req.wr_word.link = cur_q;
          nxt_ent              = 1'b1;
        end else begin
          walk_d  = ent_rd.link;
          state_d = S_PWRD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (nxt_slot) begin
      adv_d  = adv_q - (SB + 1)'(1);
      slot_d = slot_q + SB'(1);
      if (adv_q == (SB + 1)'(1)) begin
        if (wheel_q == WW'(twh_pkg::WHEEL_COUNT - 1)) begin
          state_d = S_PEND;
        end else begin
          wheel_d = wheel_q + WW'(1);
          state_d = S_WSETUP;
        end
      end else begin
        state_d = S_SRD;
      end
    end

    if (nxt_ent) begin
      cur_d   = nxt_val;
      state_d = (nxt_val == twh_pkg::NIL) ? S_FLUSH : S_HRD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_time_q  <= '0;
      pend_head_q <= twh_pkg::NIL;
      pend_tail_q <= twh_pkg::NIL;
      inuse_q     <= '0;
      caller_q    <= '0;
      whold_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_time_q  <= cur_time_d;
      pend_head_q <= pend_head_d;
      pend_tail_q <= pend_tail_d;
      inuse_q     <= inuse_d;
      caller_q    <= caller_d;
      whold_q     <= whold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q       <= tick_d;
    end_q        <= end_d;
    tag_q        <= tag_d;
    kind_q       <= kind_d;
    free_q       <= free_d;
    full_q       <= full_d;
    wheel_q      <= wheel_d;
    adv_q        <= adv_d;
    slot_q       <= slot_d;
    chain_head_q <= chain_head_d;
    chain_tail_q <= chain_tail_d;
    cur_q        <= cur_d;
    nx_q         <= nx_d;
    walk_q       <= walk_d;
    pidx_q       <= pidx_d;
  end

  twh_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .req_i     (slot_req),
    .rd_head_o (slot_rd)
  );

  twh_entry_ram u_entry_ram (
    .clk_i     (clk_i),
    .req_i     (ent_req),
    .rd_word_o (ent_rd)
  );

  twh_out_buf u_out_buf (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (ob_cmd),
    .sts_o               (ob_sts),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_o       (result_kind_o),
    .result_handle_o     (result_handle_o),
    .result_event_tag_o  (result_event_tag_o),
    .result_event_kind_o (result_event_kind_o),
    .last_o              (last_o)
  );

  // Every item leaves the holding buffer empty before the next one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !ob_sts.hold_vld)
    else $error("holding buffer not empty in idle");

  // A hold by the caller or by the wheel implies the entry is allocated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((caller_q | whold_q) & ~inuse_q) == '0)
    else $error("hold on a free entry");

  // The pending queue is either empty at both ends or at neither.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_head_q == twh_pkg::NIL) == (pend_tail_q == twh_pkg::NIL))
    else $error("pending queue ends disagree");

endmodule
